// ===== rtl/ac2d_pkg.sv =====
// shared types and constants for the two-dimensional autocorrelation engine
// no dependencies; used by every module under rtl
package ac2d_pkg;

  localparam int IDXW     = 5;   // loop index and lag width
  localparam int CNTW     = 5;   // size register width
  localparam int SAMPLE_W = 32;
  localparam int SUM_W    = 64;

  // input beat kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration register indexes
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DRAIN,
    SEQ_HOLD
  } seq_state_t;

  // per-term control that travels alongside the memory reads
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

// ===== rtl/ac2d_sample_mem.sv =====
// sample store: one write port, two registered read ports
// depends on ac2d_pkg
module ac2d_sample_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [ac2d_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]                 raddr_a,
  input  logic [AW-1:0]                 raddr_b,
  output logic [ac2d_pkg::SAMPLE_W-1:0] rdata_a_r,
  output logic [ac2d_pkg::SAMPLE_W-1:0] rdata_b_r
);

  logic [ac2d_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

endmodule

// ===== rtl/ac2d_mac.sv =====
// multiply-accumulate pipeline: aligns control with read data, multiplies, sums
// depends on ac2d_pkg
module ac2d_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ac2d_pkg::mac_ctl_t            ctl,
  input  logic [ac2d_pkg::SAMPLE_W-1:0] rdata_a,
  input  logic [ac2d_pkg::SAMPLE_W-1:0] rdata_b,
  output logic [ac2d_pkg::SUM_W-1:0]    acc_r,
  output logic                          done_r
);

  ac2d_pkg::mac_ctl_t             ctl1_r;
  ac2d_pkg::mac_ctl_t             ctl2_r;
  logic [ac2d_pkg::SUM_W-1:0]     prod_r;
  logic [ac2d_pkg::SUM_W-1:0]     prod_nxt;
  logic [ac2d_pkg::SUM_W-1:0]     acc_nxt;
  logic                           done_nxt;

  // 32x32 signed product, sign extended to 64 bits
  assign prod_nxt = ac2d_pkg::SUM_W'($signed(rdata_a)) * ac2d_pkg::SUM_W'($signed(rdata_b));

  always_comb begin
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (ctl2_r.valid) begin
      acc_nxt  = ctl2_r.first ? prod_r : acc_r + prod_r;
      done_nxt = ctl2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

// ===== rtl/ac2d_seq.sv =====
// query sequencer: walks the overlapping window of a lag and issues read pairs
// depends on ac2d_pkg
module ac2d_seq #(
  parameter int MAX_COLS = 16,
  parameter int AW       = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      query_start,
  input  logic [ac2d_pkg::IDXW-1:0] lag_row,
  input  logic [ac2d_pkg::IDXW-1:0] lag_col,
  input  logic [ac2d_pkg::CNTW-1:0] rows,
  input  logic [ac2d_pkg::CNTW-1:0] cols,
  input  logic                      mac_done,
  input  logic                      out_free,
  output logic                      busy,
  output logic [AW-1:0]             raddr_a,
  output logic [AW-1:0]             raddr_b,
  output ac2d_pkg::mac_ctl_t        mac_ctl,
  output logic                      result_load,
  output logic                      oor_r
);

  localparam int AXW = 16;

  ac2d_pkg::seq_state_t state_r, state_nxt;

  logic [ac2d_pkg::IDXW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [ac2d_pkg::IDXW-1:0] i_hi_r, i_hi_nxt, j_lo_r, j_lo_nxt, j_hi_r, j_hi_nxt;
  logic [ac2d_pkg::IDXW-1:0] m_r, m_nxt, n_r, n_nxt;
  logic                      first_r, first_nxt, oor_nxt;
  logic [ac2d_pkg::IDXW-1:0] mag_m, mag_n, di, dj;
  logic                      lag_oor, row_end, last_term;

  assign mag_m   = lag_row[ac2d_pkg::IDXW-1] ? -lag_row : lag_row;
  assign mag_n   = lag_col[ac2d_pkg::IDXW-1] ? -lag_col : lag_col;
  assign lag_oor = (mag_m >= rows) || (mag_n >= cols);

  // partner position, wraps in index width but always lands in range
  assign di        = i_r + m_r;
  assign dj        = j_r + n_r;
  assign row_end   = (j_r == j_hi_r);
  assign last_term = row_end && (i_r == i_hi_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ac2d_pkg::SEQ_IDLE: begin
        if (query_start) begin
          state_nxt = lag_oor ? ac2d_pkg::SEQ_HOLD : ac2d_pkg::SEQ_RUN;
        end
      end
      ac2d_pkg::SEQ_RUN: begin
        if (last_term) begin
          state_nxt = ac2d_pkg::SEQ_DRAIN;
        end
      end
      ac2d_pkg::SEQ_DRAIN: begin
        if (mac_done) begin
          state_nxt = ac2d_pkg::SEQ_HOLD;
        end
      end
      ac2d_pkg::SEQ_HOLD: begin
        if (out_free) begin
          state_nxt = ac2d_pkg::SEQ_IDLE;
        end
      end
      default: state_nxt = ac2d_pkg::SEQ_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    i_nxt       = i_r;
    j_nxt       = j_r;
    i_hi_nxt    = i_hi_r;
    j_lo_nxt    = j_lo_r;
    j_hi_nxt    = j_hi_r;
    m_nxt       = m_r;
    n_nxt       = n_r;
    first_nxt   = first_r;
    oor_nxt     = oor_r;
    mac_ctl     = '0;
    result_load = 1'b0;
    busy        = 1'b1;
    case (state_r)
      ac2d_pkg::SEQ_IDLE: begin
        busy = 1'b0;
        if (query_start) begin
          m_nxt     = lag_row;
          n_nxt     = lag_col;
          oor_nxt   = lag_oor;
          first_nxt = 1'b1;
          i_nxt     = lag_row[ac2d_pkg::IDXW-1] ? mag_m : '0;
          i_hi_nxt  = lag_row[ac2d_pkg::IDXW-1] ? rows - 1'b1 : rows - 1'b1 - mag_m;
          j_nxt     = lag_col[ac2d_pkg::IDXW-1] ? mag_n : '0;
          j_lo_nxt  = lag_col[ac2d_pkg::IDXW-1] ? mag_n : '0;
          j_hi_nxt  = lag_col[ac2d_pkg::IDXW-1] ? cols - 1'b1 : cols - 1'b1 - mag_n;
        end
      end
      ac2d_pkg::SEQ_RUN: begin
        mac_ctl.valid = 1'b1;
        mac_ctl.first = first_r;
        mac_ctl.last  = last_term;
        first_nxt     = 1'b0;
        if (row_end) begin
          j_nxt = j_lo_r;
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ac2d_pkg::SEQ_DRAIN: begin
        mac_ctl = '0;
      end
      ac2d_pkg::SEQ_HOLD: begin
        result_load = out_free;
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  assign raddr_a = AW'(AXW'(i_r) * AXW'(MAX_COLS) + AXW'(j_r));
  assign raddr_b = AW'(AXW'(di) * AXW'(MAX_COLS) + AXW'(dj));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ac2d_pkg::SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    i_hi_r  <= i_hi_nxt;
    j_lo_r  <= j_lo_nxt;
    j_hi_r  <= j_hi_nxt;
    m_r     <= m_nxt;
    n_r     <= n_nxt;
    first_r <= first_nxt;
    oor_r   <= oor_nxt;
  end

endmodule

// ===== rtl/autocorrelation_2d_engine.sv =====
// top level of the two-dimensional autocorrelation engine
// depends on ac2d_pkg, ac2d_sample_mem, ac2d_mac, ac2d_seq
//
// Holds a matrix of signed 32-bit samples (up to MAX_ROWS x MAX_COLS, row-major
// in a two-read, one-write memory) and answers lag queries. A store beat writes
// one sample and produces no result; stores outside the physical store are
// dropped. A query beat with lag (m,n) returns the wrapping 64-bit sum of
// s[i][j]*s[i+m][j+n] over the in-use window, one product per cycle, so a query
// occupies the engine while every product of the window passes through the read,
// multiply and accumulate registers. The single multiply-accumulate fed by the
// two memory read ports sets this rate. A lag whose magnitude reaches the size in
// use returns zero with lag_out_of_range set. One query is in flight at a time;
// in_stall is high while it runs, and a finished result waits in the output
// register while the next beat is taken. The sample memory has no reset; reading
// a location never written gives an arbitrary value. Size registers are to be
// written only while the engine is idle; the block does not enforce this. A count
// of zero acts as one and a count beyond the maximum acts as the maximum.
module autocorrelation_2d_engine #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [3:0]  in_sample_row,
  input  logic [3:0]  in_sample_col,
  input  logic signed [31:0] in_sample_value,
  input  logic signed [4:0]  in_lag_row,
  input  logic signed [4:0]  in_lag_col,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [63:0] out_correlation_sum,
  output logic        out_lag_out_of_range
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AXW   = 16;
  localparam int CMPW  = 9;
  // largest count the 5-bit register can actually select
  localparam logic [ac2d_pkg::CNTW-1:0] ROWS_CAP =
    ac2d_pkg::CNTW'((MAX_ROWS < 31) ? MAX_ROWS : 31);
  localparam logic [ac2d_pkg::CNTW-1:0] COLS_CAP =
    ac2d_pkg::CNTW'((MAX_COLS < 31) ? MAX_COLS : 31);

  logic [ac2d_pkg::CNTW-1:0] row_count_r, row_count_nxt;
  logic [ac2d_pkg::CNTW-1:0] column_count_r, column_count_nxt;
  logic [ac2d_pkg::CNTW-1:0] rows_eff, cols_eff;

  logic                  in_accept, store_we, query_start, busy;
  logic [AW-1:0]         waddr, raddr_a, raddr_b;
  logic [ac2d_pkg::SAMPLE_W-1:0] rdata_a, rdata_b;
  ac2d_pkg::mac_ctl_t    mac_ctl;
  logic [ac2d_pkg::SUM_W-1:0] acc;
  logic                  mac_done, result_load, oor, out_free;

  logic                       out_valid_r, out_valid_nxt;
  logic [ac2d_pkg::SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic                       out_oor_r, out_oor_nxt;

  // size registers
  always_comb begin
    row_count_nxt    = row_count_r;
    column_count_nxt = column_count_r;
    if (cfg_we) begin
      case (cfg_index)
        ac2d_pkg::REG_ROW_COUNT:    row_count_nxt    = cfg_wdata;
        ac2d_pkg::REG_COLUMN_COUNT: column_count_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ac2d_pkg::CNTW'(16);
      column_count_r <= ac2d_pkg::CNTW'(16);
    end else begin
      row_count_r    <= row_count_nxt;
      column_count_r <= column_count_nxt;
    end
  end

  // zero acts as one, anything past the store size acts as the store size
  assign rows_eff = (row_count_r == '0) ? ac2d_pkg::CNTW'(1) :
                    (CMPW'(row_count_r) > CMPW'(MAX_ROWS)) ? ROWS_CAP : row_count_r;
  assign cols_eff = (column_count_r == '0) ? ac2d_pkg::CNTW'(1) :
                    (CMPW'(column_count_r) > CMPW'(MAX_COLS)) ? COLS_CAP : column_count_r;

  // input handshake
  assign in_stall    = busy;
  assign in_accept   = in_valid && !busy;
  assign query_start = in_accept && (in_kind == ac2d_pkg::KIND_QUERY);
  assign store_we    = in_accept && (in_kind == ac2d_pkg::KIND_STORE) &&
                       (CMPW'(in_sample_row) < CMPW'(MAX_ROWS)) &&
                       (CMPW'(in_sample_col) < CMPW'(MAX_COLS));
  assign waddr = AW'(AXW'(in_sample_row) * AXW'(MAX_COLS) + AXW'(in_sample_col));

  ac2d_sample_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .we        (store_we),
    .waddr     (waddr),
    .wdata     (in_sample_value),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a_r (rdata_a),
    .rdata_b_r (rdata_b)
  );

  ac2d_seq #(
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .query_start (query_start),
    .lag_row     (in_lag_row),
    .lag_col     (in_lag_col),
    .rows        (rows_eff),
    .cols        (cols_eff),
    .mac_done    (mac_done),
    .out_free    (out_free),
    .busy        (busy),
    .raddr_a     (raddr_a),
    .raddr_b     (raddr_b),
    .mac_ctl     (mac_ctl),
    .result_load (result_load),
    .oor_r       (oor)
  );

  ac2d_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .acc_r   (acc),
    .done_r  (mac_done)
  );

  // output register: free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    out_oor_nxt   = out_oor_r;
    if (result_load) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = oor ? '0 : acc;
      out_oor_nxt   = oor;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
    out_oor_r <= out_oor_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_correlation_sum  = out_sum_r;
  assign out_lag_out_of_range = out_oor_r;

endmodule

// ===== dv/autocorrelation_2d_checker.sv =====
`timescale 1ns / 100ps
// scoreboard for the two-dimensional autocorrelation engine: watches the size
// writes and both channels, predicts each lag query and compares the results
// depends on ac2d_pkg
module autocorrelation_2d_checker #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_kind,
  input  logic [3:0]         in_sample_row,
  input  logic [3:0]         in_sample_col,
  input  logic signed [31:0] in_sample_value,
  input  logic signed [4:0]  in_lag_row,
  input  logic signed [4:0]  in_lag_col,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [63:0] out_correlation_sum,
  input  logic               out_lag_out_of_range,
  output int                 fail_count,
  output int                 pending,
  output int                 checked_count
);

  typedef struct {
    logic signed [63:0] sum;
    logic               out_of_range;
  } lag_result_t;

  logic signed [31:0] sample_copy [MAX_ROWS*MAX_COLS];
  logic [4:0]         row_count_copy;
  logic [4:0]         col_count_copy;
  lag_result_t        expected_sums [$];

  // zero acts as one, anything past the maximum acts as the maximum
  function automatic int size_in_use(logic [4:0] count, int limit);
    if (count == 0) return 1;
    if (int'(count) > limit) return limit;
    return int'(count);
  endfunction

  function automatic lag_result_t correlate_lag(logic signed [4:0] lag_r,
                                                logic signed [4:0] lag_c);
    lag_result_t res;
    int rows, cols, m, n, di, dj;
    longint acc;
    rows = size_in_use(row_count_copy, MAX_ROWS);
    cols = size_in_use(col_count_copy, MAX_COLS);
    m = lag_r;
    n = lag_c;
    acc = 0;
    res.out_of_range = ((m < 0 ? -m : m) >= rows) || ((n < 0 ? -n : n) >= cols);
    if (!res.out_of_range) begin
      for (int i = 0; i < rows; i++) begin
        di = i + m;
        if (di < 0 || di >= rows) continue;
        for (int j = 0; j < cols; j++) begin
          dj = j + n;
          if (dj < 0 || dj >= cols) continue;
          acc += longint'(sample_copy[i*MAX_COLS + j]) *
                 longint'(sample_copy[di*MAX_COLS + dj]);
        end
      end
    end
    res.sum = acc;
    return res;
  endfunction

  always @(posedge clk) begin : observe
    lag_result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      row_count_copy = 5'd16;
      col_count_copy = 5'd16;
      expected_sums.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ac2d_pkg::REG_ROW_COUNT)
          row_count_copy = cfg_wdata;
        else if (cfg_index == ac2d_pkg::REG_COLUMN_COUNT)
          col_count_copy = cfg_wdata;
      end
      // results first: a query can never finish on the edge that takes it
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: result beat with no query waiting, sum %0d flag %0b",
                   $time, out_correlation_sum, out_lag_out_of_range);
          errs++;
        end else begin
          want = expected_sums.pop_front();
          if (out_correlation_sum !== want.sum) begin
            $display("%0t: correlation_sum expected %0d actual %0d",
                     $time, want.sum, out_correlation_sum);
            errs++;
          end
          if (out_lag_out_of_range !== want.out_of_range) begin
            $display("%0t: lag_out_of_range expected %0b actual %0b",
                     $time, want.out_of_range, out_lag_out_of_range);
            errs++;
          end
          checked_count <= checked_count + 1;
        end
      end
      if (in_valid && !in_stall) begin
        if (in_kind == ac2d_pkg::KIND_STORE)
          sample_copy[int'(in_sample_row)*MAX_COLS + int'(in_sample_col)] = in_sample_value;
        else
          expected_sums.push_back(correlate_lag(in_lag_row, in_lag_col));
      end
      pending <= expected_sums.size();
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== dv/autocorrelation_2d_engine_test.sv =====
`timescale 1ns / 100ps
// stimulus and verdict for the two-dimensional autocorrelation engine
// depends on ac2d_pkg, autocorrelation_2d_engine and autocorrelation_2d_checker
module autocorrelation_2d_engine_test;

  localparam int MAX_ROWS      = 16;
  localparam int MAX_COLS      = 16;
  localparam int BEATS_PER_RUN = 80;    // random beats in each phase
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 800;   // receiver hold-off that backs up the engine
  localparam int DRAIN_LIMIT   = 5000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = ac2d_pkg::REG_ROW_COUNT;
  logic [4:0]         cfg_wdata = 5'd0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = ac2d_pkg::KIND_STORE;
  logic [3:0]         in_sample_row = 4'd0;
  logic [3:0]         in_sample_col = 4'd0;
  logic signed [31:0] in_sample_value = 32'sd0;
  logic signed [4:0]  in_lag_row = 5'sd0;
  logic signed [4:0]  in_lag_col = 5'sd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] out_correlation_sum;
  logic               out_lag_out_of_range;
  int                 fail_count;
  int                 pending;
  int                 checked_count;

  // idling knobs, in percent per cycle
  int   gap_pct = 0;
  int   stall_pct = 0;
  // long receiver hold-off, requested once by the stimulus
  logic hold_request = 1'b0;
  logic hold_spent = 1'b0;
  int   hold_left = 0;

  // size in use as the engine sees it, so lags can be aimed inside the window
  int rows_in_use = MAX_ROWS;
  int cols_in_use = MAX_COLS;
  int stores_sent = 0;
  int queries_sent = 0;

  autocorrelation_2d_engine DUT (.*);

  autocorrelation_2d_checker #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) checker_inst (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: random stalls, or the long hold-off once it is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_spent) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_spent <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // offer one beat, with random gaps ahead of it, and hold it until taken
  task automatic send_beat(input logic kind, input logic [3:0] row, input logic [3:0] col,
                           input logic signed [31:0] value,
                           input logic signed [4:0] lag_r, input logic signed [4:0] lag_c);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_sample_row <= row;
    in_sample_col <= col;
    in_sample_value <= value;
    in_lag_row <= lag_r;
    in_lag_col <= lag_c;
    do @(posedge clk); while (in_stall);
    if (kind == ac2d_pkg::KIND_QUERY) queries_sent++;
    else stores_sent++;
  endtask

  // mostly lags inside the window, now and then any 5-bit value
  function automatic logic signed [4:0] pick_lag(int size);
    int k;
    if ($urandom_range(99) < 15) return 5'($urandom_range(31));
    k = int'($urandom_range(2*size - 2)) - (size - 1);
    return k[4:0];
  endfunction

  task automatic random_beats(int count);
    logic               kind;
    logic signed [31:0] value;
    for (int b = 0; b < count; b++) begin
      kind = ($urandom_range(99) < 55) ? ac2d_pkg::KIND_QUERY : ac2d_pkg::KIND_STORE;
      case ($urandom_range(7))
        0:       value = 32'sh7fffffff;
        1:       value = 32'sh80000000;
        2:       value = -32'sd1;
        3:       value = 32'sd0;
        default: value = $urandom;
      endcase
      // fields the beat does not use still carry noise
      send_beat(kind, 4'($urandom_range(15)), 4'($urandom_range(15)), value,
                pick_lag(rows_in_use), pick_lag(cols_in_use));
    end
  endtask

  // drop valid, wait out every expected result, then let the engine go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both size registers on back-to-back cycles, only while idle
  task automatic write_sizes(logic [4:0] rows_raw, logic [4:0] cols_raw);
    cfg_we <= 1'b1;
    cfg_index <= ac2d_pkg::REG_ROW_COUNT;
    cfg_wdata <= rows_raw;
    @(posedge clk);
    cfg_index <= ac2d_pkg::REG_COLUMN_COUNT;
    cfg_wdata <= cols_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_in_use = (rows_raw == 0) ? 1 : (int'(rows_raw) > MAX_ROWS ? MAX_ROWS : rows_raw);
    cols_in_use = (cols_raw == 0) ? 1 : (int'(cols_raw) > MAX_COLS ? MAX_COLS : cols_raw);
  endtask

  task automatic set_idling(int sender_pct, int receiver_pct);
    gap_pct = sender_pct;
    stall_pct <= receiver_pct;
  endtask

  initial begin
    int                 drain_cycles;
    logic signed [31:0] fill_value;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 1: reset size 16x16, no idling
    // every location is written before the first query so no read hits an unwritten sample;
    // row 0 at the positive extreme and row 15 at the negative one make the sums wrap
    set_idling(0, 0);
    for (int r = 0; r < MAX_ROWS; r++) begin
      for (int c = 0; c < MAX_COLS; c++) begin
        if (r == 0) fill_value = 32'sh7fffffff;
        else if (r == MAX_ROWS - 1) fill_value = 32'sh80000000;
        else if (c == 0) fill_value = -32'sd1;
        else fill_value = $urandom;
        send_beat(ac2d_pkg::KIND_STORE, 4'(r), 4'(c), fill_value, 5'sd0, 5'sd0);
      end
    end

    // directed: field extremes on stores, then corner and edge lags
    send_beat(ac2d_pkg::KIND_STORE, 4'd0, 4'd0, 32'sh80000000, 5'sd0, 5'sd0);
    send_beat(ac2d_pkg::KIND_STORE, 4'd15, 4'd15, 32'sh7fffffff, 5'sb10000, 5'sd15);
    send_beat(ac2d_pkg::KIND_STORE, 4'd0, 4'd15, 32'sd0, 5'sd0, 5'sd0);
    send_beat(ac2d_pkg::KIND_STORE, 4'd15, 4'd0, -32'sd1, 5'sd0, 5'sd0);
    send_beat(ac2d_pkg::KIND_QUERY, 4'd0, 4'd0, 32'sd0, 5'sd0, 5'sd0);
    send_beat(ac2d_pkg::KIND_QUERY, 4'd15, 4'd15, 32'sh7fffffff, 5'sd15, 5'sd15);
    send_beat(ac2d_pkg::KIND_QUERY, 4'd0, 4'd0, 32'sd0, -5'sd15, -5'sd15);
    send_beat(ac2d_pkg::KIND_QUERY, 4'd0, 4'd0, 32'sd0, 5'sd15, -5'sd15);
    send_beat(ac2d_pkg::KIND_QUERY, 4'd0, 4'd0, 32'sd0, -5'sd15, 5'sd15);
    // row 0 against row 15
    send_beat(ac2d_pkg::KIND_QUERY, 4'd0, 4'd0, 32'sd0, 5'sd15, 5'sd0);
    // a lag of -16 is always flagged
    send_beat(ac2d_pkg::KIND_QUERY, 4'd0, 4'd0, 32'sd0, 5'sb10000, 5'sd0);
    send_beat(ac2d_pkg::KIND_QUERY, 4'd0, 4'd0, 32'sd0, 5'sd0, 5'sb10000);
    send_beat(ac2d_pkg::KIND_QUERY, 4'd0, 4'd0, 32'sd0, 5'sb10000, 5'sb10000);
    send_beat(ac2d_pkg::KIND_QUERY, 4'd0, 4'd0, 32'sd0, 5'sd1, -5'sd1);
    send_beat(ac2d_pkg::KIND_QUERY, 4'd0, 4'd0, 32'sd0, -5'sd3, 5'sd7);
    send_beat(ac2d_pkg::KIND_QUERY, 4'd0, 4'd0, 32'sd0, 5'sd14, 5'sd0);
    send_beat(ac2d_pkg::KIND_QUERY, 4'd0, 4'd0, 32'sd0, 5'sd0, -5'sd14);
    random_beats(BEATS_PER_RUN);
    settle();

    // phase 2: smallest window, sender idling
    write_sizes(5'd1, 5'd1);
    set_idling(49, 0);
    random_beats(BEATS_PER_RUN);
    settle();

    // phase 3: out-of-range register values, zero acts as one and 31 as the maximum
    write_sizes(5'd0, 5'd31);
    set_idling(0, 49);
    random_beats(BEATS_PER_RUN);
    settle();

    // phase 4: random small window, both sides idling
    write_sizes(5'($urandom_range(8, 2)), 5'($urandom_range(8, 2)));
    set_idling(35, 35);
    random_beats(BEATS_PER_RUN);
    settle();

    // phase 5: full window with the long hold-off so in_stall has to rise
    write_sizes(5'd16, 5'd16);
    set_idling(0, 0);
    hold_request <= 1'b1;
    random_beats(BEATS_PER_RUN);
    settle();

    // phase 6: any register value, sender idling
    write_sizes(5'($urandom_range(31)), 5'($urandom_range(31)));
    set_idling(49, 0);
    random_beats(BEATS_PER_RUN);
    in_valid <= 1'b0;

    drain_cycles = 0;
    do begin
      @(posedge clk);
      drain_cycles++;
    end while (pending != 0 && drain_cycles < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending != 0)
      $display("%0t: %0d query results never arrived", $time, pending);
    $display("covered %0d store beats and %0d query beats, %0d results checked",
             stores_sent, queries_sent, checked_count);
    $display("six phases: windows from 1x1 to 16x16, clamped counts, idling and a long hold-off");
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // hang guard, several times the slowest correct run
  initial begin
    #2000000;
    $display("%0t: run did not complete, %0d results outstanding", $time, pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== autocorrelation_2d_engine.f =====
rtl/ac2d_pkg.sv
rtl/ac2d_sample_mem.sv
rtl/ac2d_mac.sv
rtl/ac2d_seq.sv
rtl/autocorrelation_2d_engine.sv
dv/autocorrelation_2d_checker.sv
dv/autocorrelation_2d_engine_test.sv
